>>> hdl/bsc_pkg.sv
package bsc_pkg;

  // calibration fields unpacked from the configuration registers
  typedef struct packed {
    logic        [15:0] t1;
    logic        [15:0] t2;
    logic signed [7:0]  t3;
    logic signed [15:0] p1;
    logic signed [15:0] p2;
    logic signed [7:0]  p3;
    logic signed [7:0]  p4;
    logic        [15:0] p5;
    logic        [15:0] p6;
    logic signed [7:0]  p7;
    logic signed [7:0]  p8;
    logic signed [15:0] p9;
    logic signed [7:0]  p10;
    logic signed [7:0]  p11;
  } bsc_coeffs_t;

  typedef enum logic [1:0] {
    REG_TEMP    = 2'd0,
    REG_PRESS_A = 2'd1,
    REG_PRESS_B = 2'd2,
    REG_PRESS_C = 2'd3
  } bsc_reg_idx_t;

  localparam int NUM_STAGES = 11;
  localparam int ACC_W      = 48;

  localparam int    P_OFFSET     = 16384;
  localparam int    TEMP_MIN_Q24 = -40 * (2 ** 24);
  localparam int    TEMP_MAX_Q24 = 85 * (2 ** 24);
  localparam longint PRES_MIN_Q16 = 64'sd30000 * 64'sd65536;
  localparam longint PRES_MAX_Q16 = 64'sd125000 * 64'sd65536;

endpackage

>>> hdl/bsc_datapath.sv
module bsc_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bsc_pkg::bsc_coeffs_t coeffs,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [47:0]          in_tdata,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [31:0]          out_tdata
);
  import bsc_pkg::*;

  localparam int NS = NUM_STAGES;

  logic [NS:1]   v_r;
  logic [NS+1:1] en;

  // stage 1
  logic signed [24:0] s1_d_r, s1_d_nxt;
  logic        [47:0] s1_rsq_r, s1_rsq_nxt;
  logic signed [40:0] s1_rp1_r, s1_rp1_nxt, s1_rp2_r, s1_rp2_nxt;
  logic signed [31:0] s1_rp3_r, s1_rp3_nxt, s1_rp4_r, s1_rp4_nxt, s1_rp11_r, s1_rp11_nxt;
  // stage 2
  logic signed [41:0] s2_dt2_r, s2_dt2_nxt;
  logic        [48:0] s2_dd_r, s2_dd_nxt;
  logic signed [63:0] s2_r2p9_r, s2_r2p9_nxt;
  logic signed [56:0] s2_r2p10_r, s2_r2p10_nxt;
  logic signed [56:0] s2_clo_r, s2_clo_nxt, s2_chi_r, s2_chi_nxt;
  logic signed [40:0] s2_rp1_r, s2_rp2_r;
  logic signed [31:0] s2_rp3_r, s2_rp4_r;
  // stage 3
  logic signed [59:0] s3_tnum_r, s3_tnum_nxt;
  logic signed [36:0] s3_erp1_r, s3_erp1_nxt;
  logic signed [31:0] s3_er2p9_r, s3_er2p9_nxt;
  logic signed [31:0] s3_ecube_r, s3_ecube_nxt;
  logic signed [40:0] s3_rp2_r;
  logic signed [31:0] s3_rp3_r, s3_rp4_r;
  logic signed [56:0] s3_r2p10_r;
  // stage 4
  logic signed [31:0]    s4_t_r, s4_t_nxt;
  logic signed [7:0]     s4_tc_r, s4_tc_nxt;
  logic signed [ACC_W-1:0] s4_acc_r, s4_acc_nxt;
  logic signed [40:0] s4_rp2_r;
  logic signed [31:0] s4_rp3_r, s4_rp4_r;
  logic signed [56:0] s4_r2p10_r;
  // stage 5
  logic signed [63:0] s5_sq_r, s5_sq_nxt;
  logic signed [48:0] s5_pt6_r, s5_pt6_nxt;
  logic signed [52:0] s5_rp2lo_r, s5_rp2lo_nxt, s5_rp2hi_r, s5_rp2hi_nxt;
  logic signed [60:0] s5_r10lo_r, s5_r10lo_nxt, s5_r10hi_r, s5_r10hi_nxt;
  logic signed [31:0] s5_t_r;
  logic signed [7:0]  s5_tc_r;
  logic signed [ACC_W-1:0] s5_acc_r;
  logic signed [31:0] s5_rp3_r, s5_rp4_r;
  // stage 6
  logic        [36:0] s6_tsq_r, s6_tsq_nxt;
  logic signed [34:0] s6_ep6_r, s6_ep6_nxt;
  logic signed [37:0] s6_erp2_r, s6_erp2_nxt;
  logic signed [32:0] s6_er10_r, s6_er10_nxt;
  logic signed [31:0] s6_t_r;
  logic signed [7:0]  s6_tc_r;
  logic signed [ACC_W-1:0] s6_acc_r;
  logic signed [31:0] s6_rp3_r, s6_rp4_r;
  // stage 7
  logic signed [ACC_W-1:0] s7_acc_r, s7_acc_nxt;
  logic signed [56:0] s7_culo_r, s7_culo_nxt;
  logic signed [45:0] s7_cuhi_r, s7_cuhi_nxt;
  logic signed [45:0] s7_p7tsq_r, s7_p7tsq_nxt;
  logic signed [56:0] s7_rp3lo_r, s7_rp3lo_nxt;
  logic signed [45:0] s7_rp3hi_r, s7_rp3hi_nxt;
  logic signed [7:0]  s7_tc_r;
  logic signed [31:0] s7_rp4_r;
  // stage 8
  logic signed [45:0] s8_tcu_r, s8_tcu_nxt;
  logic signed [ACC_W-1:0] s8_acc_r, s8_acc_nxt;
  logic signed [7:0]  s8_tc_r;
  logic signed [31:0] s8_rp4_r;
  // stage 9
  logic signed [30:0] s9_ep8_r, s9_ep8_nxt;
  logic signed [56:0] s9_rp4lo_r, s9_rp4lo_nxt;
  logic signed [53:0] s9_rp4hi_r, s9_rp4hi_nxt;
  logic signed [ACC_W-1:0] s9_acc_r;
  logic signed [7:0]  s9_tc_r;
  // stage 10
  logic signed [ACC_W-1:0] s10_acc_r, s10_acc_nxt;
  logic signed [7:0]  s10_tc_r;
  // stage 11, output register
  logic        [16:0] s11_pres_r, s11_pres_nxt;
  logic signed [7:0]  s11_tc_r;

  // stall control: a stage loads when it is empty or the next one moves
  always_comb begin
    en[NS+1] = out_tready;
    for (int k = NS; k >= 1; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_tready  = en[1];
  assign out_tvalid = v_r[NS];
  assign out_tdata  = {7'd0, s11_pres_r, s11_tc_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[1]) begin
        v_r[1] <= in_tvalid;
      end
      for (int k = 2; k <= NS; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // stage 1: offset, raw pressure products
  always_comb begin
    logic signed [24:0] rs;
    logic signed [16:0] p1o, p2o;
    rs          = $signed({1'b0, in_tdata[47:24]});
    p1o         = 17'(coeffs.p1) - 17'sd16384;
    p2o         = 17'(coeffs.p2) - 17'(P_OFFSET);
    s1_d_nxt    = $signed({1'b0, in_tdata[23:0]}) - $signed({1'b0, coeffs.t1, 8'd0});
    s1_rsq_nxt  = 48'(in_tdata[47:24]) * 48'(in_tdata[47:24]);
    s1_rp1_nxt  = 41'(rs) * 41'(p1o);
    s1_rp2_nxt  = 41'(rs) * 41'(p2o);
    s1_rp3_nxt  = 32'(rs) * 32'(coeffs.p3);
    s1_rp4_nxt  = 32'(rs) * 32'(coeffs.p4);
    s1_rp11_nxt = 32'(rs) * 32'(coeffs.p11);
  end

  // stage 2: temperature products, r^2 products, cube split in halves
  always_comb begin
    logic signed [49:0] ddf;
    ddf          = 50'(s1_d_r) * 50'(s1_d_r);
    s2_dd_nxt    = ddf[48:0];
    s2_dt2_nxt   = 42'(s1_d_r) * 42'($signed({1'b0, coeffs.t2}));
    s2_r2p9_nxt  = 64'($signed({1'b0, s1_rsq_r})) * 64'(coeffs.p9);
    s2_r2p10_nxt = 57'($signed({1'b0, s1_rsq_r})) * 57'(coeffs.p10);
    s2_clo_nxt   = 57'($signed({1'b0, s1_rsq_r[23:0]})) * 57'(s1_rp11_r);
    s2_chi_nxt   = 57'($signed({1'b0, s1_rsq_r[47:24]})) * 57'(s1_rp11_r);
  end

  // stage 3: temperature numerator, first pressure terms
  always_comb begin
    logic signed [80:0] cube;
    logic signed [80:0] cube_sh;
    logic signed [63:0] r9_sh;
    logic signed [40:0] r1_sh;
    s3_tnum_nxt  = (60'(s2_dt2_r) <<< 18) + 60'($signed({1'b0, s2_dd_r})) * 60'(coeffs.t3);
    r1_sh        = s2_rp1_r >>> 4;
    s3_erp1_nxt  = r1_sh[36:0];
    r9_sh        = s2_r2p9_r >>> 32;
    s3_er2p9_nxt = r9_sh[31:0];
    cube         = (81'(s2_chi_r) <<< 24) + 81'(s2_clo_r);
    cube_sh      = cube >>> 49;
    s3_ecube_nxt = cube_sh[31:0];
  end

  // stage 4: temperature clamp, whole degrees, first partial sum
  always_comb begin
    logic signed [35:0] tsh;
    logic signed [31:0] tcl;
    logic        [31:0] tmag;
    tsh = 36'(s3_tnum_r >>> 24);
    if (tsh < 36'(TEMP_MIN_Q24)) begin
      tcl = 32'(TEMP_MIN_Q24);
    end else if (tsh > 36'(TEMP_MAX_Q24)) begin
      tcl = 32'(TEMP_MAX_Q24);
    end else begin
      tcl = tsh[31:0];
    end
    s4_t_nxt   = tcl;
    // truncate toward zero
    tmag       = tcl[31] ? 32'(-tcl) : 32'(tcl);
    s4_tc_nxt  = tcl[31] ? -$signed(tmag[31:24]) : $signed(tmag[31:24]);
    s4_acc_nxt = ($signed(ACC_W'(coeffs.p5)) <<< 19) + ACC_W'(s3_erp1_r)
               + ACC_W'(s3_er2p9_r) + ACC_W'(s3_ecube_r);
  end

  // stage 5: products with T
  always_comb begin
    s5_sq_nxt    = 64'(s4_t_r) * 64'(s4_t_r);
    s5_pt6_nxt   = 49'($signed({1'b0, coeffs.p6})) * 49'(s4_t_r);
    s5_rp2lo_nxt = 53'($signed({1'b0, s4_rp2_r[19:0]})) * 53'(s4_t_r);
    s5_rp2hi_nxt = 53'($signed(s4_rp2_r[40:20])) * 53'(s4_t_r);
    s5_r10lo_nxt = 61'($signed({1'b0, s4_r2p10_r[27:0]})) * 61'(s4_t_r);
    s5_r10hi_nxt = 61'($signed(s4_r2p10_r[56:28])) * 61'(s4_t_r);
  end

  // stage 6: T^2, terms linear in T
  always_comb begin
    logic signed [48:0] p6_sh;
    logic signed [74:0] rp2, rp2_sh;
    logic signed [88:0] r10, r10_sh;
    s6_tsq_nxt  = s5_sq_r[60:24];
    p6_sh       = s5_pt6_r >>> 14;
    s6_ep6_nxt  = p6_sh[34:0];
    rp2         = (75'(s5_rp2hi_r) <<< 20) + 75'(s5_rp2lo_r);
    rp2_sh      = rp2 >>> 37;
    s6_erp2_nxt = rp2_sh[37:0];
    r10         = (89'(s5_r10hi_r) <<< 28) + 89'(s5_r10lo_r);
    r10_sh      = r10 >>> 56;
    s6_er10_nxt = r10_sh[32:0];
  end

  // stage 7: linear terms into the sum, products with T^2
  always_comb begin
    s7_acc_nxt   = s6_acc_r + ACC_W'(s6_ep6_r) + ACC_W'(s6_erp2_r) + ACC_W'(s6_er10_r);
    s7_culo_nxt  = 57'($signed({1'b0, s6_tsq_r[23:0]})) * 57'(s6_t_r);
    s7_cuhi_nxt  = 46'($signed({1'b0, s6_tsq_r[36:24]})) * 46'(s6_t_r);
    s7_p7tsq_nxt = 46'(coeffs.p7) * 46'($signed({1'b0, s6_tsq_r}));
    s7_rp3lo_nxt = 57'(s6_rp3_r) * 57'($signed({1'b0, s6_tsq_r[23:0]}));
    s7_rp3hi_nxt = 46'(s6_rp3_r) * 46'($signed({1'b0, s6_tsq_r[36:24]}));
  end

  // stage 8: T^3, terms in T^2
  always_comb begin
    logic signed [69:0] cu, cu_sh, rp3, rp3_sh;
    logic signed [45:0] p7_sh;
    cu         = (70'(s7_cuhi_r) <<< 24) + 70'(s7_culo_r);
    cu_sh      = cu >>> 24;
    s8_tcu_nxt = cu_sh[45:0];
    p7_sh      = s7_p7tsq_r >>> 16;
    rp3        = (70'(s7_rp3hi_r) <<< 24) + 70'(s7_rp3lo_r);
    rp3_sh     = rp3 >>> 40;
    s8_acc_nxt = s7_acc_r + ACC_W'($signed(p7_sh[29:0])) + ACC_W'($signed(rp3_sh[29:0]));
  end

  // stage 9: products with T^3
  always_comb begin
    logic signed [53:0] p8t, p8_sh;
    p8t          = 54'(coeffs.p8) * 54'(s8_tcu_r);
    p8_sh        = p8t >>> 23;
    s9_ep8_nxt   = p8_sh[30:0];
    s9_rp4lo_nxt = 57'(s8_rp4_r) * 57'($signed({1'b0, s8_tcu_r[23:0]}));
    s9_rp4hi_nxt = 54'(s8_rp4_r) * 54'($signed(s8_tcu_r[45:24]));
  end

  // stage 10: last terms into the sum
  always_comb begin
    logic signed [77:0] rp4, rp4_sh;
    rp4         = (78'(s9_rp4hi_r) <<< 24) + 78'(s9_rp4lo_r);
    rp4_sh      = rp4 >>> 45;
    s10_acc_nxt = s9_acc_r + ACC_W'(s9_ep8_r) + ACC_W'($signed(rp4_sh[32:0]));
  end

  // stage 11: pressure clamp, whole pascals
  always_comb begin
    logic signed [ACC_W-1:0] pcl;
    if (s10_acc_r < ACC_W'(PRES_MIN_Q16)) begin
      pcl = ACC_W'(PRES_MIN_Q16);
    end else if (s10_acc_r > ACC_W'(PRES_MAX_Q16)) begin
      pcl = ACC_W'(PRES_MAX_Q16);
    end else begin
      pcl = s10_acc_r;
    end
    s11_pres_nxt = pcl[32:16];
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_d_r    <= s1_d_nxt;
      s1_rsq_r  <= s1_rsq_nxt;
      s1_rp1_r  <= s1_rp1_nxt;
      s1_rp2_r  <= s1_rp2_nxt;
      s1_rp3_r  <= s1_rp3_nxt;
      s1_rp4_r  <= s1_rp4_nxt;
      s1_rp11_r <= s1_rp11_nxt;
    end
    if (en[2]) begin
      s2_dt2_r   <= s2_dt2_nxt;
      s2_dd_r    <= s2_dd_nxt;
      s2_r2p9_r  <= s2_r2p9_nxt;
      s2_r2p10_r <= s2_r2p10_nxt;
      s2_clo_r   <= s2_clo_nxt;
      s2_chi_r   <= s2_chi_nxt;
      s2_rp1_r   <= s1_rp1_r;
      s2_rp2_r   <= s1_rp2_r;
      s2_rp3_r   <= s1_rp3_r;
      s2_rp4_r   <= s1_rp4_r;
    end
    if (en[3]) begin
      s3_tnum_r  <= s3_tnum_nxt;
      s3_erp1_r  <= s3_erp1_nxt;
      s3_er2p9_r <= s3_er2p9_nxt;
      s3_ecube_r <= s3_ecube_nxt;
      s3_rp2_r   <= s2_rp2_r;
      s3_rp3_r   <= s2_rp3_r;
      s3_rp4_r   <= s2_rp4_r;
      s3_r2p10_r <= s2_r2p10_r;
    end
    if (en[4]) begin
      s4_t_r     <= s4_t_nxt;
      s4_tc_r    <= s4_tc_nxt;
      s4_acc_r   <= s4_acc_nxt;
      s4_rp2_r   <= s3_rp2_r;
      s4_rp3_r   <= s3_rp3_r;
      s4_rp4_r   <= s3_rp4_r;
      s4_r2p10_r <= s3_r2p10_r;
    end
    if (en[5]) begin
      s5_sq_r    <= s5_sq_nxt;
      s5_pt6_r   <= s5_pt6_nxt;
      s5_rp2lo_r <= s5_rp2lo_nxt;
      s5_rp2hi_r <= s5_rp2hi_nxt;
      s5_r10lo_r <= s5_r10lo_nxt;
      s5_r10hi_r <= s5_r10hi_nxt;
      s5_t_r     <= s4_t_r;
      s5_tc_r    <= s4_tc_r;
      s5_acc_r   <= s4_acc_r;
      s5_rp3_r   <= s4_rp3_r;
      s5_rp4_r   <= s4_rp4_r;
    end
    if (en[6]) begin
      s6_tsq_r  <= s6_tsq_nxt;
      s6_ep6_r  <= s6_ep6_nxt;
      s6_erp2_r <= s6_erp2_nxt;
      s6_er10_r <= s6_er10_nxt;
      s6_t_r    <= s5_t_r;
      s6_tc_r   <= s5_tc_r;
      s6_acc_r  <= s5_acc_r;
      s6_rp3_r  <= s5_rp3_r;
      s6_rp4_r  <= s5_rp4_r;
    end
    if (en[7]) begin
      s7_acc_r   <= s7_acc_nxt;
      s7_culo_r  <= s7_culo_nxt;
      s7_cuhi_r  <= s7_cuhi_nxt;
      s7_p7tsq_r <= s7_p7tsq_nxt;
      s7_rp3lo_r <= s7_rp3lo_nxt;
      s7_rp3hi_r <= s7_rp3hi_nxt;
      s7_tc_r    <= s6_tc_r;
      s7_rp4_r   <= s6_rp4_r;
    end
    if (en[8]) begin
      s8_tcu_r <= s8_tcu_nxt;
      s8_acc_r <= s8_acc_nxt;
      s8_tc_r  <= s7_tc_r;
      s8_rp4_r <= s7_rp4_r;
    end
    if (en[9]) begin
      s9_ep8_r   <= s9_ep8_nxt;
      s9_rp4lo_r <= s9_rp4lo_nxt;
      s9_rp4hi_r <= s9_rp4hi_nxt;
      s9_acc_r   <= s8_acc_r;
      s9_tc_r    <= s8_tc_r;
    end
    if (en[10]) begin
      s10_acc_r <= s10_acc_nxt;
      s10_tc_r  <= s9_tc_r;
    end
    if (en[11]) begin
      s11_pres_r <= s11_pres_nxt;
      s11_tc_r   <= s10_tc_r;
    end
  end

endmodule

>>> hdl/barometer_sample_compensation.sv
// throughput: one item per cycle unless back-pressure on out_tready stalls the
// pipeline; the widest products are split into partial products over the
// eleven-stage multiplier pipeline
// reset: synchronous active-low rst_n empties the pipeline and clears all
// calibration registers to zero
module barometer_sample_compensation (
  input  logic        clk,
  input  logic        rst_n,
  // input item
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // raw_temperature [23:0], raw_pressure [47:24]
  // result item
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // temperature_c [7:0], pressure_pa [24:8], zero pad
  // calibration register port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);
  import bsc_pkg::*;

  // packed calibration words
  logic [39:0] temp_coeffs_r;
  logic [47:0] press_coeffs_a_r;
  logic [47:0] press_coeffs_b_r;
  logic [31:0] press_coeffs_c_r;

  bsc_reg_idx_t reg_idx;
  logic         wr_en;
  bsc_coeffs_t  coeffs;

  // registers sit on 8-byte boundaries, low address bits are ignored
  assign reg_idx    = bsc_reg_idx_t'(cfg_paddr[4:3]);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_coeffs_r    <= '0;
      press_coeffs_a_r <= '0;
      press_coeffs_b_r <= '0;
      press_coeffs_c_r <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_TEMP:    temp_coeffs_r    <= cfg_pwdata[39:0];
        REG_PRESS_A: press_coeffs_a_r <= cfg_pwdata[47:0];
        REG_PRESS_B: press_coeffs_b_r <= cfg_pwdata[47:0];
        REG_PRESS_C: press_coeffs_c_r <= cfg_pwdata[31:0];
        default: ;
      endcase
    end
  end

  // read back, zero extended
  always_comb begin
    case (reg_idx)
      REG_TEMP:    cfg_prdata = 64'(temp_coeffs_r);
      REG_PRESS_A: cfg_prdata = 64'(press_coeffs_a_r);
      REG_PRESS_B: cfg_prdata = 64'(press_coeffs_b_r);
      REG_PRESS_C: cfg_prdata = 64'(press_coeffs_c_r);
      default:     cfg_prdata = '0;
    endcase
  end

  // unpacking; user must change coefficients only while pipeline is idle (unchecked)
  always_comb begin
    coeffs.t1  = temp_coeffs_r[15:0];
    coeffs.t2  = temp_coeffs_r[31:16];
    coeffs.t3  = $signed(temp_coeffs_r[39:32]);
    coeffs.p1  = $signed(press_coeffs_a_r[15:0]);
    coeffs.p2  = $signed(press_coeffs_a_r[31:16]);
    coeffs.p3  = $signed(press_coeffs_a_r[39:32]);
    coeffs.p4  = $signed(press_coeffs_a_r[47:40]);
    coeffs.p5  = press_coeffs_b_r[15:0];
    coeffs.p6  = press_coeffs_b_r[31:16];
    coeffs.p7  = $signed(press_coeffs_b_r[39:32]);
    coeffs.p8  = $signed(press_coeffs_b_r[47:40]);
    coeffs.p9  = $signed(press_coeffs_c_r[15:0]);
    coeffs.p10 = $signed(press_coeffs_c_r[23:16]);
    coeffs.p11 = $signed(press_coeffs_c_r[31:24]);
  end

  // temperature quadratic, clamp, then the cubic pressure polynomial;
  // every stage holds under back-pressure and fills bubbles behind a stall
  bsc_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .coeffs     (coeffs),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
